// File: design/tcad_pkg.sv
// ----------------------------------------------------------------------------
// tcad_pkg
// Types and constants shared by the Type-C CC attach/detach detector.
// ----------------------------------------------------------------------------
package tcad_pkg;

    localparam int unsigned CodeW     = 3;
    localparam int unsigned LevelW    = 8;
    localparam int unsigned TimerW    = 16;
    localparam int unsigned CfgIndexW = 3;
    localparam int unsigned CfgDataW  = 16;

    localparam logic [CodeW-1:0] CODE_NONE = 3'h0;
    localparam logic [CodeW-1:0] CODE_RA   = 3'h1;
    localparam logic [CodeW-1:0] CODE_RD   = 3'h2;
    localparam logic [CodeW-1:0] CODE_OPEN = 3'h4;

    localparam logic [CfgIndexW-1:0] REG_THRESH_HIGH  = 3'd0;
    localparam logic [CfgIndexW-1:0] REG_THRESH_LOW   = 3'd1;
    localparam logic [CfgIndexW-1:0] REG_CC_DEBOUNCE  = 3'd2;
    localparam logic [CfgIndexW-1:0] REG_PD_DEBOUNCE  = 3'd3;
    localparam logic [CfgIndexW-1:0] REG_SLEEP_TICKS  = 3'd4;
    localparam logic [CfgIndexW-1:0] REG_SLEEP_ENABLE = 3'd5;
    localparam logic [CfgIndexW-1:0] REG_DIRECT_SENSE = 3'd6;

    typedef struct packed {
        logic [LevelW-1:0] cc1_level;
        logic [LevelW-1:0] cc2_level;
    } t_in_item;

    typedef struct packed {
        logic [CodeW-1:0] cc1_status;
        logic [CodeW-1:0] cc2_status;
        logic             attached;
        logic             flipped;
        logic             cable_ra;
        logic             sleeping;
        logic             wake_event;
        logic             sleep_event;
    } t_out_item;

    typedef struct packed {
        logic [LevelW-1:0] thresh_high;
        logic [LevelW-1:0] thresh_low;
        logic [TimerW-1:0] cc_debounce_ticks;
        logic [TimerW-1:0] pd_debounce_ticks;
        logic [TimerW-1:0] sleep_ticks;
        logic              sleep_enable;
        logic              direct_sense;
    } t_cfg;

    function automatic logic [CodeW-1:0] classify(
        input logic [LevelW-1:0] level,
        input logic [LevelW-1:0] thresh_high,
        input logic [LevelW-1:0] thresh_low
    );
        logic [CodeW-1:0] code;
        if (level >= thresh_high) begin
            code = CODE_OPEN;
        end else if (level >= thresh_low) begin
            code = CODE_RD;
        end else begin
            code = CODE_RA;
        end
        return code;
    endfunction

endpackage

// File: design/tcad_cfg.sv
// ----------------------------------------------------------------------------
// tcad_cfg
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module tcad_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tcad_pkg::CfgIndexW-1:0]    i_cfg_index,
    input  logic [tcad_pkg::CfgDataW-1:0]     i_cfg_data,
    output tcad_pkg::t_cfg                    o_cfg
);

    tcad_pkg::t_cfg r_cfg;
    logic           wr_en;

    assign o_cfg_ready = 1'b1;
    assign wr_en       = i_cfg_valid;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thresh_high       <= 8'd100;
            r_cfg.thresh_low        <= 8'd20;
            r_cfg.cc_debounce_ticks <= 16'd150;
            r_cfg.pd_debounce_ticks <= 16'd15;
            r_cfg.sleep_ticks       <= 16'd1000;
            r_cfg.sleep_enable      <= 1'b1;
            r_cfg.direct_sense      <= 1'b1;
        end else if (wr_en) begin
            case (i_cfg_index)
                tcad_pkg::REG_THRESH_HIGH:  r_cfg.thresh_high       <= i_cfg_data[7:0];
                tcad_pkg::REG_THRESH_LOW:   r_cfg.thresh_low        <= i_cfg_data[7:0];
                tcad_pkg::REG_CC_DEBOUNCE:  r_cfg.cc_debounce_ticks <= i_cfg_data;
                tcad_pkg::REG_PD_DEBOUNCE:  r_cfg.pd_debounce_ticks <= i_cfg_data;
                tcad_pkg::REG_SLEEP_TICKS:  r_cfg.sleep_ticks       <= i_cfg_data;
                tcad_pkg::REG_SLEEP_ENABLE: r_cfg.sleep_enable      <= i_cfg_data[0];
                tcad_pkg::REG_DIRECT_SENSE: r_cfg.direct_sense      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

endmodule

// File: design/tcad_core.sv
// ----------------------------------------------------------------------------
// tcad_core
// CC classification, debounce/sleep timer and attach state, one tick per step.
// ----------------------------------------------------------------------------
module tcad_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  tcad_pkg::t_in_item   i_item,
    input  tcad_pkg::t_cfg       i_cfg,
    output tcad_pkg::t_out_item  o_result
);

    logic [tcad_pkg::CodeW-1:0]  r_cc1, n_cc1;
    logic [tcad_pkg::CodeW-1:0]  r_cc2, n_cc2;
    logic [tcad_pkg::TimerW-1:0] r_timer, n_timer;
    logic                        r_attach, n_attach;
    logic                        r_sleep, n_sleep;
    logic                        r_debounce, n_debounce;
    logic                        r_flip, n_flip;
    logic                        r_cable, n_cable;

    logic [tcad_pkg::CodeW-1:0]  cls1, cls2, active;
    logic [tcad_pkg::TimerW-1:0] timer_dec;
    logic                        run_timer, expire, changed, one_rd;
    logic                        woke, slept;

    assign cls1 = tcad_pkg::classify(i_item.cc1_level, i_cfg.thresh_high, i_cfg.thresh_low);
    assign cls2 = tcad_pkg::classify(i_item.cc2_level, i_cfg.thresh_high, i_cfg.thresh_low);

    always_comb begin
        n_cc1 = r_cc1;
        n_cc2 = r_cc2;
        if (r_sleep || !r_attach) begin
            n_cc1 = cls1;
            n_cc2 = cls2;
        end else if (r_flip) begin
            n_cc2 = i_cfg.direct_sense ? cls2 : tcad_pkg::CODE_RD;
        end else begin
            n_cc1 = i_cfg.direct_sense ? cls1 : tcad_pkg::CODE_RD;
        end
    end

    assign run_timer = !r_sleep && (r_timer != '0);
    assign timer_dec = r_timer - 16'd1;
    assign expire    = run_timer && (timer_dec == '0);
    assign changed   = (n_cc1 != r_cc1) || (n_cc2 != r_cc2);
    assign one_rd    = n_cc1[1] ^ n_cc2[1];
    assign active    = r_flip ? n_cc2 : n_cc1;

    always_comb begin
        n_timer    = run_timer ? timer_dec : r_timer;
        n_attach   = r_attach;
        n_sleep    = r_sleep;
        n_debounce = r_debounce;
        n_flip     = r_flip;
        n_cable    = r_cable;
        woke       = 1'b0;
        slept      = 1'b0;
        if (changed) begin
            if (r_sleep && one_rd) begin
                n_sleep = 1'b0;
                woke    = 1'b1;
            end
            if (!n_sleep) begin
                if (r_attach) begin
                    n_timer = i_cfg.pd_debounce_ticks;
                end else begin
                    n_timer    = i_cfg.cc_debounce_ticks;
                    n_debounce = 1'b1;
                end
            end
        end else if (expire) begin
            if (r_attach) begin
                if (active[2]) begin
                    n_attach = 1'b0;
                    if (i_cfg.sleep_enable) begin
                        n_timer = i_cfg.sleep_ticks;
                    end
                end
            end else if (r_debounce) begin
                n_debounce = 1'b0;
                if (one_rd) begin
                    n_attach = 1'b1;
                    n_cable  = n_cc1[0] | n_cc2[0];
                    n_flip   = !n_cc1[1];
                end else if (i_cfg.sleep_enable) begin
                    n_timer = i_cfg.sleep_ticks;
                end
            end else begin
                n_sleep = 1'b1;
                slept   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc1      <= tcad_pkg::CODE_NONE;
            r_cc2      <= tcad_pkg::CODE_NONE;
            r_timer    <= '0;
            r_attach   <= 1'b0;
            r_sleep    <= 1'b0;
            r_debounce <= 1'b0;
            r_flip     <= 1'b0;
            r_cable    <= 1'b0;
        end else if (i_step) begin
            r_cc1      <= n_cc1;
            r_cc2      <= n_cc2;
            r_timer    <= n_timer;
            r_attach   <= n_attach;
            r_sleep    <= n_sleep;
            r_debounce <= n_debounce;
            r_flip     <= n_flip;
            r_cable    <= n_cable;
        end
    end

    always_comb begin
        o_result.cc1_status  = n_cc1;
        o_result.cc2_status  = n_cc2;
        o_result.attached    = n_attach;
        o_result.flipped     = n_flip;
        o_result.cable_ra    = n_cable;
        o_result.sleeping    = n_sleep;
        o_result.wake_event  = woke;
        o_result.sleep_event = slept;
    end

`ifndef SYNTHESIS
    a_sleep_detached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sleep |-> !r_attach)
        else $error("attached while sleeping");
    a_attach_no_debounce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_attach |-> !r_debounce)
        else $error("debounce pending while attached");
    a_sleep_timer_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sleep |-> (r_timer == '0))
        else $error("timer armed while sleeping");
    a_wake_from_sleep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && woke) |=> !$past(r_sleep) == 1'b0)
        else $error("wake without prior sleep");
`endif

endmodule

// File: design/typec_cc_attach_detect_top.sv
// ----------------------------------------------------------------------------
// typec_cc_attach_detect_top
// USB Type-C source CC attach/detach detector with debounce and sleep timer.
// ----------------------------------------------------------------------------
// the result of each accepted input is registered in the output register
// throughput: one transaction per cycle, limited by the single-tick state update
// input is taken whenever the output register is empty or being drained
// reset (synchronous, active low) clears state and loads default register values
// configuration writes are taken every cycle
module typec_cc_attach_detect_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  tcad_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output tcad_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tcad_pkg::CfgIndexW-1:0]  i_cfg_index,
    input  logic [tcad_pkg::CfgDataW-1:0]   i_cfg_data
);

    tcad_pkg::t_cfg      cfg;
    tcad_pkg::t_out_item result;
    tcad_pkg::t_out_item r_out_data;
    logic                r_out_valid;
    logic                step;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign step        = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    tcad_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tcad_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (i_in_data),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= result;
        end
    end

endmodule

// File: verif/typec_cc_attach_detect_top_tb.sv
// ----------------------------------------------------------------------------
// typec_cc_attach_detect_top_tb
// Self-checking bench for the Type-C CC attach/detach detector. A driver
// streams CC level ticks, a monitor accepts results under random stalls, and
// a cycle-free model of the detector predicts each result. Register settings
// change between phases while the block is idle, covering threshold extremes,
// crossed thresholds, minimum, zero and maximum timers, sleep and wake.
// ----------------------------------------------------------------------------
module typec_cc_attach_detect_top_tb;
    import tcad_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int MaxPrinted    = 40;
    localparam int TailCycles    = 8;

    localparam logic [CfgIndexW-1:0] REG_UNUSED = 3'd7;

    localparam t_cfg DefaultRegs = '{8'd100, 8'd20, 16'd150, 16'd15, 16'd1000, 1'b1, 1'b1};

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_item             in_data   = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CfgIndexW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0]  cfg_data  = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_cfg_ready;
    t_out_item            o_out_data;

    typec_cc_attach_detect_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // stimulus and handshake bookkeeping
    t_in_item  tick_backlog[$];
    t_out_item status_due[$];
    int        n_queued      = 0;
    int        n_taken       = 0;
    int        n_checked     = 0;
    int        n_errors      = 0;
    int        gap_in_max    = 0;
    int        gap_out_max   = 0;
    int        in_gap_left   = 0;
    int        out_wait_left = 0;
    int        hold_left     = 0;
    int        idle_cycles   = 0;
    logic      in_taken_now  = 1'b0;
    logic      out_taken_now = 1'b0;
    int        plan_th, plan_tl, plan_span;

    // coverage tallies
    int n_attach = 0, n_flip_attach = 0, n_detach = 0;
    int n_sleep = 0, n_wake = 0, n_in_stall = 0, n_settings = 0;

    // detector model state
    t_cfg              reg_copy;
    logic [7:0]        cc_state;
    logic [TimerW-1:0] tick_left;
    logic              attach_q, sleep_q, debounce_q, flip_q, cable_q;

    function automatic logic [CodeW-1:0] code_of(input logic [LevelW-1:0] level);
        if (level >= reg_copy.thresh_high) return CODE_OPEN;
        if (level >= reg_copy.thresh_low) return CODE_RD;
        return CODE_RA;
    endfunction

    function automatic logic single_rd(input logic [7:0] st);
        return st[1] ^ st[5];
    endfunction

    function automatic t_out_item advance_tick(input t_in_item tick_in);
        logic [7:0]       prior;
        logic             expired;
        logic             woke;
        logic             slept;
        logic [CodeW-1:0] active;
        t_out_item        res;
        prior   = cc_state;
        expired = 1'b0;
        woke    = 1'b0;
        slept   = 1'b0;
        if (sleep_q || !attach_q) begin
            cc_state = {1'b0, code_of(tick_in.cc2_level), 1'b0, code_of(tick_in.cc1_level)};
        end else if (flip_q) begin
            cc_state = {1'b0, reg_copy.direct_sense ? code_of(tick_in.cc2_level) : CODE_RD,
                        cc_state[3:0]};
        end else begin
            cc_state = {cc_state[7:4], 1'b0,
                        reg_copy.direct_sense ? code_of(tick_in.cc1_level) : CODE_RD};
        end
        if (!sleep_q && tick_left != '0) begin
            tick_left = tick_left - 1'b1;
            expired = (tick_left == '0);
        end
        if (cc_state != prior) begin
            if (sleep_q && single_rd(cc_state)) begin
                sleep_q = 1'b0;
                woke    = 1'b1;
            end
            if (!sleep_q) begin
                if (attach_q) begin
                    tick_left = reg_copy.pd_debounce_ticks;
                end else begin
                    tick_left  = reg_copy.cc_debounce_ticks;
                    debounce_q = 1'b1;
                end
            end
        end else if (expired) begin
            if (attach_q) begin
                active = flip_q ? cc_state[6:4] : cc_state[2:0];
                if ((active & CODE_OPEN) != '0) begin
                    attach_q = 1'b0;
                    if (reg_copy.sleep_enable) tick_left = reg_copy.sleep_ticks;
                end
            end else if (debounce_q) begin
                debounce_q = 1'b0;
                if (single_rd(cc_state)) begin
                    attach_q = 1'b1;
                    cable_q  = ((cc_state[2:0] | cc_state[6:4]) & CODE_RA) != '0;
                    flip_q   = (cc_state[2:0] & CODE_RD) == '0;
                end else if (reg_copy.sleep_enable) begin
                    tick_left = reg_copy.sleep_ticks;
                end
            end else begin
                sleep_q = 1'b1;
                slept   = 1'b1;
            end
        end
        res.cc1_status  = cc_state[2:0];
        res.cc2_status  = cc_state[6:4];
        res.attached    = attach_q;
        res.flipped     = flip_q;
        res.cable_ra    = cable_q;
        res.sleeping    = sleep_q;
        res.wake_event  = woke;
        res.sleep_event = slept;
        return res;
    endfunction

    task automatic apply_reg_write(input logic [CfgIndexW-1:0] idx,
                                   input logic [CfgDataW-1:0] val);
        case (idx)
            REG_THRESH_HIGH:  reg_copy.thresh_high       = val[LevelW-1:0];
            REG_THRESH_LOW:   reg_copy.thresh_low        = val[LevelW-1:0];
            REG_CC_DEBOUNCE:  reg_copy.cc_debounce_ticks = val;
            REG_PD_DEBOUNCE:  reg_copy.pd_debounce_ticks = val;
            REG_SLEEP_TICKS:  reg_copy.sleep_ticks       = val;
            REG_SLEEP_ENABLE: reg_copy.sleep_enable      = val[0];
            REG_DIRECT_SENSE: reg_copy.direct_sense      = val[0];
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (n_errors < MaxPrinted) begin
            $display("mismatch at result %0d: %s got %0h want %0h", n_checked, what, got, want);
        end
        n_errors++;
    endtask

    task automatic check_field(input string what, input logic [CodeW-1:0] got,
                               input logic [CodeW-1:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // monitor side: result check, then prediction for the accepted transaction
    always @(posedge i_clk) begin
        t_out_item want;
        logic      was_attached;
        logic      was_sleeping;
        in_taken_now  = i_rst_n && in_valid && o_in_ready;
        out_taken_now = i_rst_n && o_out_valid && out_ready;
        if (!i_rst_n) begin
            reg_copy   = DefaultRegs;
            cc_state   = '0;
            tick_left  = '0;
            attach_q   = 1'b0;
            sleep_q    = 1'b0;
            debounce_q = 1'b0;
            flip_q     = 1'b0;
            cable_q    = 1'b0;
        end else begin
            if (cfg_valid && o_cfg_ready) apply_reg_write(cfg_index, cfg_data);
            if (in_valid && !o_in_ready) n_in_stall++;
            if (out_taken_now) begin
                n_checked++;
                if (status_due.size() == 0) begin
                    report_mismatch("result with nothing due", o_out_data, '0);
                end else begin
                    want = status_due.pop_front();
                    check_field("cc1_status", o_out_data.cc1_status, want.cc1_status);
                    check_field("cc2_status", o_out_data.cc2_status, want.cc2_status);
                    check_field("attached", o_out_data.attached, want.attached);
                    check_field("flipped", o_out_data.flipped, want.flipped);
                    check_field("cable_ra", o_out_data.cable_ra, want.cable_ra);
                    check_field("sleeping", o_out_data.sleeping, want.sleeping);
                    check_field("wake_event", o_out_data.wake_event, want.wake_event);
                    check_field("sleep_event", o_out_data.sleep_event, want.sleep_event);
                end
            end
            if (in_taken_now) begin
                was_attached = attach_q;
                was_sleeping = sleep_q;
                status_due.push_back(advance_tick(in_data));
                n_taken++;
                if (!was_attached && attach_q) begin
                    n_attach++;
                    if (flip_q) n_flip_attach++;
                end
                if (was_attached && !attach_q) n_detach++;
                if (!was_sleeping && sleep_q) n_sleep++;
                if (was_sleeping && !sleep_q) n_wake++;
            end
        end
    end

    // driver: one tick per transaction, random gap after each
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_taken_now) begin
            // hold until accepted
        end else if (in_gap_left > 0) begin
            in_valid <= 1'b0;
            in_gap_left--;
        end else if (tick_backlog.size() != 0) begin
            in_valid    <= 1'b1;
            in_data     <= tick_backlog.pop_front();
            in_gap_left = $urandom_range(0, gap_in_max);
        end else begin
            in_valid <= 1'b0;
        end
    end

    // receiver: random stall per result, long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            if (out_taken_now) out_wait_left = $urandom_range(0, gap_out_max);
            if (out_wait_left > 0) begin
                out_wait_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)
                || (cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WatchdogLimit) begin
            $display("no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, status_due.size());
            $display("typec_cc_attach_detect_top verification failed");
            $finish;
        end
    end

    task automatic queue_item(input logic [LevelW-1:0] lvl1, input logic [LevelW-1:0] lvl2);
        t_in_item tick_in;
        tick_in.cc1_level = lvl1;
        tick_in.cc2_level = lvl2;
        tick_backlog.push_back(tick_in);
        n_queued++;
    endtask

    function automatic logic [LevelW-1:0] pick_level(input logic [CodeW-1:0] code);
        int lo;
        int hi;
        case (code)
            CODE_OPEN: begin
                lo = plan_th;
                hi = 255;
            end
            CODE_RD: begin
                lo = plan_tl;
                hi = plan_th - 1;
            end
            default: begin
                lo = 0;
                hi = plan_tl - 1;
            end
        endcase
        // class out of reach under this setting
        if (lo > hi) return $urandom_range(0, 255);
        return $urandom_range(lo, hi);
    endfunction

    function automatic logic [CodeW-1:0] any_code();
        case ($urandom_range(0, 2))
            0: return CODE_RA;
            1: return CODE_RD;
            default: return CODE_OPEN;
        endcase
    endfunction

    task automatic queue_random(input int n_items);
        int               to_go;
        int               run;
        logic [CodeW-1:0] c1;
        logic [CodeW-1:0] c2;
        logic [15:0]      noise;
        to_go = n_items;
        while (to_go > 0) begin
            if ($urandom_range(0, 4) == 0) begin
                noise = $urandom;
                queue_item(noise[15:8], noise[7:0]);
                to_go--;
            end else begin
                case ($urandom_range(0, 7))
                    0: begin c1 = CODE_RD;   c2 = CODE_OPEN; end
                    1: begin c1 = CODE_OPEN; c2 = CODE_RD;   end
                    2: begin c1 = CODE_RD;   c2 = CODE_RA;   end
                    3: begin c1 = CODE_RA;   c2 = CODE_RD;   end
                    4: begin c1 = CODE_OPEN; c2 = CODE_OPEN; end
                    default: begin c1 = any_code(); c2 = any_code(); end
                endcase
                run = $urandom_range(1, plan_span);
                while (run > 0 && to_go > 0) begin
                    queue_item(pick_level(c1), pick_level(c2));
                    run--;
                    to_go--;
                end
            end
        end
    endtask

    task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // unused upper data bits carry random junk
    task automatic set_registers(input int th, input int tl, input int ccd, input int pdd,
                                 input int slp, input bit en, input bit ds);
        logic [15:0] junk;
        junk = $urandom;
        write_reg(REG_THRESH_HIGH, {junk[15:8], th[7:0]});
        junk = $urandom;
        write_reg(REG_THRESH_LOW, {junk[15:8], tl[7:0]});
        write_reg(REG_CC_DEBOUNCE, ccd[15:0]);
        write_reg(REG_PD_DEBOUNCE, pdd[15:0]);
        write_reg(REG_SLEEP_TICKS, slp[15:0]);
        junk = $urandom;
        write_reg(REG_SLEEP_ENABLE, {junk[15:1], en});
        junk = $urandom;
        write_reg(REG_DIRECT_SENSE, {junk[15:1], ds});
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
        plan_th   = th;
        plan_tl   = tl;
        plan_span = ccd + pdd + slp + 3;
        if (plan_span > 24) plan_span = 24;
        n_settings++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (n_taken != n_queued || status_due.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic run_phase(input int th, input int tl, input int ccd, input int pdd,
                             input int slp, input bit en, input bit ds, input int gi,
                             input int go, input int hold, input int n_items);
        set_registers(th, tl, ccd, pdd, slp, en, ds);
        gap_in_max  = gi;
        gap_out_max = go;
        hold_left   = hold;
        queue_random(n_items);
        wait_idle();
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // level extremes and threshold edges under reset settings
        queue_item(8'd0, 8'd0);
        queue_item(8'd255, 8'd255);
        queue_item(8'd19, 8'd20);
        queue_item(8'd99, 8'd100);
        queue_item(8'd20, 8'd19);
        queue_item(8'd100, 8'd99);
        queue_item(8'd200, 8'd200);
        wait_idle();

        // attach, detach, sleep, ignored change, wake, flipped attach with ra
        set_registers(100, 20, 2, 1, 2, 1'b1, 1'b1);
        queue_item(8'd50, 8'd200);
        queue_item(8'd60, 8'd150);
        queue_item(8'd70, 8'd255);
        queue_item(8'd40, 8'd0);
        queue_item(8'd100, 8'd0);
        queue_item(8'd120, 8'd0);
        queue_item(8'd200, 8'd200);
        queue_item(8'd255, 8'd255);
        queue_item(8'd50, 8'd50);
        queue_item(8'd5, 8'd5);
        queue_item(8'd5, 8'd50);
        queue_item(8'd0, 8'd99);
        queue_item(8'd19, 8'd20);
        queue_item(8'd200, 8'd50);
        queue_item(8'd200, 8'd200);
        queue_item(8'd0, 8'd200);
        wait_idle();

        run_phase(100, 20, 3, 2, 5, 1'b1, 1'b1, 16, 16, 0, 300);
        run_phase(255, 0, 1, 1, 1, 1'b1, 1'b0, 0, 0, 0, 200);
        write_reg(REG_UNUSED, $urandom);
        run_phase(0, 255, 65535, 65535, 65535, 1'b0, 1'b1, 2, 2, 0, 100);
        run_phase(60, 200, 4, 3, 0, 1'b1, 1'b0, 3, 3, 0, 200);
        run_phase(128, 32, 6, 4, 8, 1'b1, 1'b1, 16, 3, 300, 400);
        run_phase(200, 50, 2, 5, 3, 1'b0, 1'b0, 0, 16, 0, 200);

        repeat (TailCycles) @(posedge i_clk);
        if (status_due.size() != 0) begin
            report_mismatch("results never delivered", status_due.size(), '0);
        end

        $display("run covered %0d ticks under %0d register settings, input stalled %0d cycles",
                 n_taken, n_settings, n_in_stall);
        $display("model saw %0d attaches (%0d flipped), %0d detaches, %0d sleeps, %0d wakes",
                 n_attach, n_flip_attach, n_detach, n_sleep, n_wake);
        if (n_errors == 0) begin
            $display("typec_cc_attach_detect_top verification clean");
        end else begin
            $display("typec_cc_attach_detect_top verification failed");
        end
        $finish;
    end

endmodule
